// File: hw/rtl/pfr_pkg.sv
// Shared types, constants and the helper function of the pixel format to RGBA converter.
package pfr_pkg;

    // Fixed field widths.
    localparam int PIXEL_BITS   = 32;
    localparam int SIZE_BITS    = 10;
    localparam int SCREEN_BITS  = 11;
    localparam int CHAN_BITS    = 8;
    localparam int FORMAT_BITS  = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 10;

    localparam int COORD_BITS_DEFAULT = 10;

    // Pixel format codes; the unused code decodes as 32-bit BGRA.
    localparam logic [FORMAT_BITS-1:0] FMT_RGB332 = 2'd0;
    localparam logic [FORMAT_BITS-1:0] FMT_RGB565 = 2'd1;
    localparam logic [FORMAT_BITS-1:0] FMT_BGRA32 = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_PIXEL_FORMAT  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPACITY_8BIT  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OPACITY_16BIT = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [SIZE_BITS-1:0] SIZE_RESET    = 10'd1;
    localparam logic [CHAN_BITS-1:0] OPACITY_RESET = 8'd100;

    // Transparent key colours.
    localparam logic [7:0]  KEY_RGB332 = 8'hC0;
    localparam logic [15:0] KEY_RGB565 = 16'hE000;

    // Alpha scaling for 32-bit pixels: floor(100 * a / 255).
    localparam int ALPHA_SCALE   = 100;
    localparam int PROD_BITS     = 15;
    // x / 255 == (x * 32897) >> 23 for every x below 65536.
    localparam int RECIP_255     = 32897;
    localparam int RECIP_SHIFT   = 23;
    localparam int RECIP_BITS    = 16;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_word;
    } pixel_in_t;

    typedef struct packed {
        logic [SCREEN_BITS-1:0] screen_x;
        logic [SCREEN_BITS-1:0] screen_y;
        logic [CHAN_BITS-1:0]   red;
        logic [CHAN_BITS-1:0]   green;
        logic [CHAN_BITS-1:0]   blue;
        logic [CHAN_BITS-1:0]   alpha;
        logic                   frame_end;
    } rgba_out_t;

    // Scales an 8-bit alpha byte to the range 0..100.
    function automatic logic [CHAN_BITS-1:0] scale_alpha(input logic [CHAN_BITS-1:0] a);
        logic [PROD_BITS-1:0]                prod;
        logic [PROD_BITS+RECIP_BITS-1:0]     wide;
        prod = PROD_BITS'(a) * PROD_BITS'(ALPHA_SCALE);
        wide = (PROD_BITS+RECIP_BITS)'(prod) * (PROD_BITS+RECIP_BITS)'(RECIP_255);
        return CHAN_BITS'(wide >> RECIP_SHIFT);
    endfunction

endpackage

// File: hw/rtl/pfr_stream_if.sv
// Valid/ready stream channel carrying one payload item per handshake.
interface pfr_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/pixel_format_to_rgba_raster_top.sv
// Pixel format to RGBA converter with raster position counters.
//
// Usage: pixels of one image enter in raster order on pixel_in, one item per
// handshake, and each leaves as one item on rgba_out carrying its screen
// position, its RGBA colour and a flag on the last pixel of the image.
// Both channels are valid/ready; an item moves at a rising edge where valid
// and ready are both high.
// The configuration port writes register cfg_index with cfg_data whenever
// cfg_we is high; it is meant to be used only while no item is in flight.
// The block is a two-register pipeline: an input register takes the pixel,
// and the decoded result is captured in the output register, from which it is
// offered on rgba_out. Throughput is one item per cycle with a ready receiver.
// When the receiver stalls, the output register holds its item and the input
// register may still take one more pixel; pixel_in.ready then falls until the
// output drains. No item is dropped or repeated.
// Reset clears both valid flags and the column and row counters, and returns
// the registers to RGB332, a 1 by 1 image at the origin and opacity 100.
module pixel_format_to_rgba_raster_top #(
    parameter int COORD_BITS = pfr_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pfr_stream_if.sink                         pixel_in,
    pfr_stream_if.source                       rgba_out,
    input  logic                               cfg_we,
    input  logic [pfr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [pfr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import pfr_pkg::*;

    // Width of the screen position sum before it is cut to the output width.
    localparam int SUM_BITS = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;

    // Configuration registers.
    logic [FORMAT_BITS-1:0] pixel_format_reg;
    logic [SIZE_BITS-1:0]   image_width_reg;
    logic [SIZE_BITS-1:0]   image_height_reg;
    logic [SIZE_BITS-1:0]   origin_x_reg;
    logic [SIZE_BITS-1:0]   origin_y_reg;
    logic [CHAN_BITS-1:0]   opacity_8bit_reg;
    logic [CHAN_BITS-1:0]   opacity_16bit_reg;

    // Raster counters.
    logic [COORD_BITS-1:0]  column_reg;
    logic [COORD_BITS-1:0]  column_next;
    logic [COORD_BITS-1:0]  row_reg;
    logic [COORD_BITS-1:0]  row_next;

    // Pipeline registers.
    logic                   in_valid_reg;
    logic [PIXEL_BITS-1:0]  pixel_reg;
    logic                   out_valid_reg;
    rgba_out_t              result_reg;
    rgba_out_t              result_next;

    logic                   advance;
    logic [COORD_BITS-1:0]  width_c;
    logic [COORD_BITS-1:0]  height_c;
    logic [COORD_BITS-1:0]  col_last;
    logic [COORD_BITS-1:0]  row_last;
    logic                   last_col;
    logic                   last_row;
    logic [SUM_BITS-1:0]    sum_x;
    logic [SUM_BITS-1:0]    sum_y;

    // The held pixel moves to the output register when that register is free
    // or being emptied this cycle.
    assign advance        = in_valid_reg && (!out_valid_reg || rgba_out.ready);
    assign pixel_in.ready = !in_valid_reg || advance;
    assign rgba_out.valid = out_valid_reg;
    assign rgba_out.payload = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg  <= FMT_RGB332;
            image_width_reg   <= SIZE_RESET;
            image_height_reg  <= SIZE_RESET;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            opacity_8bit_reg  <= OPACITY_RESET;
            opacity_16bit_reg <= OPACITY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PIXEL_FORMAT:  pixel_format_reg  <= cfg_data[FORMAT_BITS-1:0];
                CFG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[SIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[SIZE_BITS-1:0];
                CFG_ORIGIN_X:      origin_x_reg      <= cfg_data[SIZE_BITS-1:0];
                CFG_ORIGIN_Y:      origin_y_reg      <= cfg_data[SIZE_BITS-1:0];
                CFG_OPACITY_8BIT:  opacity_8bit_reg  <= cfg_data[CHAN_BITS-1:0];
                CFG_OPACITY_16BIT: opacity_16bit_reg <= cfg_data[CHAN_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // A size of zero, after fitting to the counter width, counts as one.
    // A counter that has reached or passed its last position wraps, which
    // also covers a size register that shrank in the middle of an image.
    always_comb
    begin
        width_c  = COORD_BITS'(image_width_reg);
        height_c = COORD_BITS'(image_height_reg);
        col_last = (width_c == '0)  ? '0 : width_c  - 1'b1;
        row_last = (height_c == '0) ? '0 : height_c - 1'b1;
        last_col = (column_reg >= col_last);
        last_row = (row_reg >= row_last);

        if (last_col)
        begin
            column_next = '0;
            row_next    = last_row ? '0 : row_reg + 1'b1;
        end
        else
        begin
            column_next = column_reg + 1'b1;
            row_next    = row_reg;
        end
    end

    // Decode of the held pixel and its screen position.
    always_comb
    begin
        sum_x = SUM_BITS'(origin_x_reg) + SUM_BITS'(column_reg);
        sum_y = SUM_BITS'(origin_y_reg) + SUM_BITS'(row_reg);

        result_next           = '0;
        result_next.screen_x  = sum_x[SCREEN_BITS-1:0];
        result_next.screen_y  = sum_y[SCREEN_BITS-1:0];
        result_next.frame_end = last_col && last_row;

        unique case (pixel_format_reg)
            FMT_RGB332:
            begin
                result_next.red   = {pixel_reg[7:5], 5'b0};
                result_next.green = {pixel_reg[4:2], 5'b0};
                result_next.blue  = {pixel_reg[1:0], 6'b0};
                result_next.alpha = (pixel_reg[7:0] == KEY_RGB332) ? '0 : opacity_8bit_reg;
            end
            FMT_RGB565:
            begin
                result_next.red   = {pixel_reg[15:11], 3'b0};
                result_next.green = {pixel_reg[10:5], 2'b0};
                result_next.blue  = {pixel_reg[4:0], 3'b0};
                result_next.alpha = (pixel_reg[15:0] == KEY_RGB565) ? '0 : opacity_16bit_reg;
            end
            default:
            begin
                // 32-bit BGRA, also taken for the spare format code.
                result_next.red   = pixel_reg[23:16];
                result_next.green = pixel_reg[15:8];
                result_next.blue  = pixel_reg[7:0];
                result_next.alpha = scale_alpha(pixel_reg[31:24]);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            column_reg    <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (pixel_in.ready)
            begin
                in_valid_reg <= pixel_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                column_reg    <= column_next;
                row_reg       <= row_next;
            end
            else if (rgba_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (pixel_in.valid && pixel_in.ready)
        begin
            pixel_reg <= pixel_in.payload.pixel_word;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// File: tb/sv/tb_pixel_format_to_rgba_raster_top.sv
// Self-checking testbench of the pixel format to RGBA raster converter.
module tb_pixel_format_to_rgba_raster_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pfr_pkg::*;

    // The register index that the block does not implement; a write to it must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

    // The format code that has no format of its own and decodes as 32-bit BGRA.
    localparam logic [FORMAT_BITS-1:0] FMT_SPARE = 2'd3;

    // Transparent key colours, kept here so that the predictor does not lean on the package.
    localparam logic [7:0]  KEY_332 = 8'hC0;
    localparam logic [15:0] KEY_565 = 16'hE000;

    // The run is abandoned after this many cycles.
    localparam int CYCLE_LIMIT = 200000;

    // Random stimulus: phases of this many items, enough for about 900 in total.
    localparam int RANDOM_PHASES    = 12;
    localparam int ITEMS_PER_PHASE  = 75;

    typedef enum logic {ROW_CONFIG, ROW_PIXEL} stim_kind_t;

    // One row of the directed table. A pixel row may carry a result typed in by hand;
    // otherwise the predictor supplies the expectation.
    typedef struct {
        stim_kind_t                 kind;
        logic [CFG_IDX_BITS-1:0]    index;
        logic [CFG_DATA_BITS-1:0]   data;
        logic [PIXEL_BITS-1:0]      word;
        bit                         typed;
        rgba_out_t                  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_BITS-1:0]    cfg_index;
    logic [CFG_DATA_BITS-1:0]   cfg_data;

    pfr_stream_if #(.payload_t(pixel_in_t)) pixel_ch ();
    pfr_stream_if #(.payload_t(rgba_out_t)) rgba_ch ();

    pixel_format_to_rgba_raster_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel_in  (pixel_ch.sink),
        .rgba_out  (rgba_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // The testbench's own copy of the registers and the raster counters.
    logic [FORMAT_BITS-1:0] fmt_reg;
    logic [SIZE_BITS-1:0]   width_reg;
    logic [SIZE_BITS-1:0]   height_reg;
    logic [SIZE_BITS-1:0]   org_x_reg;
    logic [SIZE_BITS-1:0]   org_y_reg;
    logic [CHAN_BITS-1:0]   opac8_reg;
    logic [CHAN_BITS-1:0]   opac16_reg;
    logic [SIZE_BITS-1:0]   column_pos;
    logic [SIZE_BITS-1:0]   row_pos;

    // Colours still owed by the block, oldest first.
    rgba_out_t  owed_rgba_q[$];
    stim_row_t  directed_rows[$];

    int error_count = 0;
    int result_count = 0;
    int cycle_count = 0;
    int sender_idle_pct;
    int receiver_stall_pct;

    // The clock runs with a 2 ns period.
    always #1 clk = ~clk;

    // Every mismatch ends up here: one line each, and the failure is counted.
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s is %0h, expected %0h", result_count, what, got, want);
        error_count++;
    endtask

    // Works out the colour and screen position of one accepted pixel, then moves the
    // raster counters on. A size of zero behaves as one, and a counter that already
    // lies at or past the last column or row (after a size was reduced) wraps now.
    function automatic rgba_out_t predict_rgba(input logic [PIXEL_BITS-1:0] word);
        rgba_out_t  res;
        int         last_col_idx;
        int         last_row_idx;
        bit         at_last_col;
        bit         at_last_row;
        last_col_idx = (width_reg == '0) ? 0 : int'(width_reg) - 1;
        last_row_idx = (height_reg == '0) ? 0 : int'(height_reg) - 1;
        at_last_col  = int'(column_pos) >= last_col_idx;
        at_last_row  = int'(row_pos) >= last_row_idx;

        res.screen_x  = SCREEN_BITS'(org_x_reg) + SCREEN_BITS'(column_pos);
        res.screen_y  = SCREEN_BITS'(org_y_reg) + SCREEN_BITS'(row_pos);
        res.frame_end = at_last_col && at_last_row;

        if (fmt_reg == FMT_RGB332)
        begin
            // Three bits of red and green, two of blue, each pushed to the top of the byte.
            res.red   = {word[7:5], 5'b0};
            res.green = {word[4:2], 5'b0};
            res.blue  = {word[1:0], 6'b0};
            res.alpha = (word[7:0] == KEY_332) ? 8'd0 : opac8_reg;
        end
        else if (fmt_reg == FMT_RGB565)
        begin
            res.red   = {word[15:11], 3'b0};
            res.green = {word[10:5], 2'b0};
            res.blue  = {word[4:0], 3'b0};
            res.alpha = (word[15:0] == KEY_565) ? 8'd0 : opac16_reg;
        end
        else
        begin
            // The 32-bit layout, which the spare format code also selects.
            res.red   = word[23:16];
            res.green = word[15:8];
            res.blue  = word[7:0];
            res.alpha = CHAN_BITS'((int'(word[31:24]) * 100) / 255);
        end

        if (at_last_col)
        begin
            column_pos = '0;
            row_pos    = at_last_row ? '0 : row_pos + 1'b1;
        end
        else
        begin
            column_pos = column_pos + 1'b1;
        end
        return res;
    endfunction

    // Writes one register and mirrors it in the predictor. Only called with nothing in flight.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_PIXEL_FORMAT:  fmt_reg    = data[FORMAT_BITS-1:0];
            CFG_IMAGE_WIDTH:   width_reg  = data[SIZE_BITS-1:0];
            CFG_IMAGE_HEIGHT:  height_reg = data[SIZE_BITS-1:0];
            CFG_ORIGIN_X:      org_x_reg  = data[SIZE_BITS-1:0];
            CFG_ORIGIN_Y:      org_y_reg  = data[SIZE_BITS-1:0];
            CFG_OPACITY_8BIT:  opac8_reg  = data[CHAN_BITS-1:0];
            CFG_OPACITY_16BIT: opac16_reg = data[CHAN_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Lowers valid and waits until every owed result has come back.
    task automatic drain_pipeline();
        @(negedge clk);
        pixel_ch.valid <= 1'b0;
        while (owed_rgba_q.size() != 0)
            @(negedge clk);
    endtask

    // Offers one pixel, after a random number of idle cycles, and waits for its handshake.
    // On acceptance the expectation is queued: the hand-typed one if the row has one,
    // otherwise the predictor's. The predictor always runs so that the counters move on.
    task automatic send_pixel(input logic [PIXEL_BITS-1:0] word, input bit typed,
                              input rgba_out_t want);
        rgba_out_t predicted;
        @(negedge clk);
        while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_ch.valid              <= 1'b1;
        pixel_ch.payload.pixel_word <= word;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        predicted = predict_rgba(word);
        owed_rgba_q.push_back(typed ? want : predicted);
    endtask

    task automatic add_config(input logic [CFG_IDX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
        stim_row_t row;
        row       = '{kind: ROW_CONFIG, index: idx, data: data, word: '0, typed: 1'b0,
                      want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic add_pixel(input logic [PIXEL_BITS-1:0] word);
        stim_row_t row;
        row = '{kind: ROW_PIXEL, index: '0, data: '0, word: word, typed: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    // A pixel of a 1 by 1 image at the origin, so the position is (0, 0) and the
    // frame ends on every item; only the colour has to be typed in.
    task automatic add_pixel_at_origin(input logic [PIXEL_BITS-1:0] word,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic [7:0] a);
        stim_row_t row;
        row = '{kind: ROW_PIXEL, index: '0, data: '0, word: word, typed: 1'b1, want: '0};
        row.want = '{screen_x: '0, screen_y: '0, red: r, green: g, blue: b, alpha: a,
                     frame_end: 1'b1};
        directed_rows.push_back(row);
    endtask

    // The directed part: reset values, colour extremes and key colours of each format,
    // the spare format code, the spare register index, sizes of zero, origins at the
    // top of their range and a size reduced while the counters stand past the new bound.
    task automatic build_directed_table();
        add_pixel_at_origin(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'd100);
        add_pixel_at_origin(32'hFFFF_FFFF, 8'hE0, 8'hE0, 8'hC0, 8'd100);
        add_pixel_at_origin(32'h0000_00C0, 8'hC0, 8'h00, 8'h00, 8'd0);
        // The key test looks only at the low byte.
        add_pixel_at_origin(32'hFFFF_FFC0, 8'hC0, 8'h00, 8'h00, 8'd0);
        add_config(CFG_SPARE, 10'h3FF);
        add_pixel_at_origin(32'h0000_0003, 8'h00, 8'h00, 8'hC0, 8'd100);
        add_config(CFG_OPACITY_8BIT, 10'd255);
        add_pixel_at_origin(32'h0000_001C, 8'h00, 8'hE0, 8'h00, 8'd255);
        add_config(CFG_PIXEL_FORMAT, 10'(FMT_RGB565));
        add_config(CFG_OPACITY_16BIT, 10'd255);
        add_pixel_at_origin(32'h0000_E000, 8'hE0, 8'h00, 8'h00, 8'd0);
        add_pixel_at_origin(32'hFFFF_FFFF, 8'hF8, 8'hFC, 8'hF8, 8'd255);
        add_pixel_at_origin(32'h0001_E000, 8'hE0, 8'h00, 8'h00, 8'd0);
        add_pixel_at_origin(32'h0000_E001, 8'hE0, 8'h00, 8'h08, 8'd255);
        add_config(CFG_OPACITY_16BIT, 10'd0);
        add_pixel(32'h0000_1234);
        add_config(CFG_PIXEL_FORMAT, 10'(FMT_BGRA32));
        add_pixel_at_origin(32'hFF00_0000, 8'h00, 8'h00, 8'h00, 8'd100);
        add_pixel_at_origin(32'h00FF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'd0);
        add_pixel(32'h8012_3456);
        add_config(CFG_PIXEL_FORMAT, 10'(FMT_SPARE));
        add_pixel(32'h01AA_BBCC);
        add_config(CFG_OPACITY_8BIT, 10'd0);
        add_config(CFG_PIXEL_FORMAT, 10'(FMT_RGB332));
        add_pixel(32'h0000_0025);
        // A 3 by 2 image whose origin sits at the top of the coordinate range.
        add_config(CFG_PIXEL_FORMAT, 10'(FMT_BGRA32));
        add_config(CFG_IMAGE_WIDTH, 10'd3);
        add_config(CFG_IMAGE_HEIGHT, 10'd2);
        add_config(CFG_ORIGIN_X, 10'd1023);
        add_config(CFG_ORIGIN_Y, 10'd1023);
        for (int i = 0; i < 6; i++)
            add_pixel(32'h1020_3040 * (i + 1));
        // Sizes of zero act as one.
        add_config(CFG_IMAGE_WIDTH, 10'd0);
        add_config(CFG_IMAGE_HEIGHT, 10'd0);
        add_pixel(32'h7F00_FF00);
        // Leave the column counter at 3, then shrink the image so that the column
        // counter stands past the new last column and wraps at once.
        add_config(CFG_IMAGE_WIDTH, 10'd1023);
        add_config(CFG_IMAGE_HEIGHT, 10'd1023);
        add_pixel(32'h0102_0304);
        add_pixel(32'h0506_0708);
        add_pixel(32'h090A_0B0C);
        add_config(CFG_IMAGE_WIDTH, 10'd2);
        add_config(CFG_IMAGE_HEIGHT, 10'd1);
        add_pixel(32'hF0E0_D0C0);
    endtask

    // Picks a fresh setting. Sizes are mostly small so that whole images pass often,
    // with the occasional zero or maximum; origins and opacities favour their extremes.
    task automatic randomise_config();
        logic [CFG_DATA_BITS-1:0] value;
        write_register(CFG_PIXEL_FORMAT,
                       {8'($urandom_range(0, 255)), 2'($urandom_range(0, 3))});
        for (int idx = int'(CFG_IMAGE_WIDTH); idx <= int'(CFG_OPACITY_16BIT); idx++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = '1;
                    2:       value = 10'd255;
                    default: value = (idx <= int'(CFG_IMAGE_HEIGHT))
                                     ? 10'($urandom_range(1, 6)) : 10'($urandom);
                endcase
                write_register(CFG_IDX_BITS'(idx), value);
            end
        end
    endtask

    // Random pixels, with a fair share of key colours in either narrow format.
    function automatic logic [PIXEL_BITS-1:0] random_pixel();
        logic [PIXEL_BITS-1:0] word;
        word = $urandom;
        case ($urandom_range(0, 7))
            0:       word[7:0]  = KEY_332;
            1:       word[15:0] = KEY_565;
            default: ;
        endcase
        return word;
    endfunction

    // The receiver changes ready at the falling edge and stalls at the current rate.
    always @(negedge clk)
        rgba_ch.ready <= !(receiver_stall_pct != 0 &&
                           $urandom_range(0, 99) < receiver_stall_pct);

    // Every result taken at a rising edge is held against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && rgba_ch.valid && rgba_ch.ready)
        begin
            if (owed_rgba_q.size() == 0)
            begin
                report_mismatch("unrequested result", longint'(rgba_ch.payload), longint'(0));
            end
            else
            begin
                rgba_out_t want;
                want = owed_rgba_q.pop_front();
                if (rgba_ch.payload.screen_x != want.screen_x)
                    report_mismatch("screen_x", longint'(rgba_ch.payload.screen_x),
                                    longint'(want.screen_x));
                if (rgba_ch.payload.screen_y != want.screen_y)
                    report_mismatch("screen_y", longint'(rgba_ch.payload.screen_y),
                                    longint'(want.screen_y));
                if (rgba_ch.payload.red != want.red)
                    report_mismatch("red", longint'(rgba_ch.payload.red),
                                    longint'(want.red));
                if (rgba_ch.payload.green != want.green)
                    report_mismatch("green", longint'(rgba_ch.payload.green),
                                    longint'(want.green));
                if (rgba_ch.payload.blue != want.blue)
                    report_mismatch("blue", longint'(rgba_ch.payload.blue),
                                    longint'(want.blue));
                if (rgba_ch.payload.alpha != want.alpha)
                    report_mismatch("alpha", longint'(rgba_ch.payload.alpha),
                                    longint'(want.alpha));
                if (rgba_ch.payload.frame_end != want.frame_end)
                    report_mismatch("frame_end", longint'(rgba_ch.payload.frame_end),
                                    longint'(want.frame_end));
            end
            result_count++;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        stim_row_t row;
        // Every input is known from time zero, and the registers start at their reset values.
        rst_n                       = 1'b0;
        cfg_we                      = 1'b0;
        cfg_index                   = '0;
        cfg_data                    = '0;
        pixel_ch.valid              = 1'b0;
        pixel_ch.payload.pixel_word = '0;
        fmt_reg                     = FMT_RGB332;
        width_reg                   = 10'd1;
        height_reg                  = 10'd1;
        org_x_reg                   = '0;
        org_y_reg                   = '0;
        opac8_reg                   = 8'd100;
        opac16_reg                  = 8'd100;
        column_pos                  = '0;
        row_pos                     = '0;
        sender_idle_pct             = 0;
        receiver_stall_pct          = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, walked row by row. Registers are only written once the
        // block has handed back every item it was given.
        build_directed_table();
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                drain_pipeline();
                write_register(row.index, row.data);
            end
            else
            begin
                send_pixel(row.word, row.typed, row.want);
            end
        end

        // Random phases. The idling pattern rotates through: none, a mostly idle sender,
        // a mostly stalling receiver, and both at a lighter rate. Every third phase the
        // sender stops halfway and lets the block empty out completely.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_pipeline();
            randomise_config();
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 80; receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 80;
                end
                default:
                begin
                    sender_idle_pct = 27; receiver_stall_pct = 27;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase % 3 == 0 && n == ITEMS_PER_PHASE / 2)
                    drain_pipeline();
                send_pixel(random_pixel(), 1'b0, '0);
            end
        end

        // Let everything drain, then keep watching the output so that any result that
        // nobody asked for shows up.
        drain_pipeline();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: pixel_format_to_rgba_raster_top.f
hw/rtl/pfr_pkg.sv
hw/rtl/pfr_stream_if.sv
hw/rtl/pixel_format_to_rgba_raster_top.sv
tb/sv/tb_pixel_format_to_rgba_raster_top.sv
